>>> hdl/i2cw_pkg.sv
`timescale 1ns / 1ps

package i2cw_pkg;

    localparam int HALF_BIT_CYCLES = 320;
    localparam int TIMER_W = (HALF_BIT_CYCLES > 2) ? $clog2(HALF_BIT_CYCLES) : 1;
    localparam logic [TIMER_W-1:0] TIMER_LAST = TIMER_W'(HALF_BIT_CYCLES - 1);

    localparam int PHASE_W = 6;
    localparam logic [PHASE_W-1:0] PHASE_START     = 6'd0;
    localparam logic [PHASE_W-1:0] PHASE_ADDR_LO   = 6'd1;
    localparam logic [PHASE_W-1:0] PHASE_ADDR_HI   = 6'd18;
    localparam logic [PHASE_W-1:0] PHASE_DATA_LO   = 6'd19;
    localparam logic [PHASE_W-1:0] PHASE_DATA_HI   = 6'd36;
    localparam logic [PHASE_W-1:0] PHASE_STOP_0    = 6'd37;
    localparam logic [PHASE_W-1:0] PHASE_STOP_1    = 6'd38;
    localparam logic [PHASE_W-1:0] PHASE_STOP_2    = 6'd39;
    localparam logic [PHASE_W-1:0] PHASE_LAST      = 6'd40;

    localparam logic [7:0] ADDRESS_RESET = 8'h9A;
    localparam logic [7:0] SHADOW_RESET  = 8'hFF;
    localparam logic [7:0] GAIN_MASK     = 8'h1F;
    localparam logic [7:0] BIT5_MASK     = 8'h20;
    localparam logic [7:0] BIT6_MASK     = 8'h40;
    localparam logic [7:0] BIT7_MASK     = 8'h80;

    typedef enum logic [2:0] {
        KIND_GAIN     = 3'd0,
        KIND_BIT5     = 3'd1,
        KIND_BIT6     = 3'd2,
        KIND_SHUTDOWN = 3'd3,
        KIND_DIRECT   = 3'd4
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EMIT,
        ST_HOLD
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic clear_timer;
        logic count;
        logic advance;
    } dp_cmd_t;

    typedef struct packed {
        logic kind_ok;
        logic timer_done;
        logic final_phase;
    } dp_status_t;

endpackage

>>> hdl/i2cw_if.sv
`timescale 1ns / 1ps

interface i2cw_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] value;

    modport source (output valid, output kind, output value, input ready);
    modport sink (input valid, input kind, input value, output ready);
endinterface

interface i2cw_phase_if;
    logic valid;
    logic ready;
    logic scl_level;
    logic sda_level;
    logic last;

    modport source (output valid, output scl_level, output sda_level, output last,
                    input ready);
    modport sink (input valid, input scl_level, input sda_level, input last,
                  output ready);
endinterface

>>> hdl/i2cw_ctrl.sv
`timescale 1ns / 1ps

module i2cw_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  i2cw_pkg::dp_status_t status,
    output i2cw_pkg::dp_cmd_t    dp_cmd
);

    i2cw_pkg::ctrl_state_t state_reg;
    i2cw_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= i2cw_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        cmd_ready          = 1'b0;
        out_valid          = 1'b0;
        dp_cmd.load        = 1'b0;
        dp_cmd.clear_timer = 1'b0;
        dp_cmd.count       = 1'b0;
        dp_cmd.advance     = 1'b0;
        case (state_reg)
            i2cw_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid && status.kind_ok)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = i2cw_pkg::ST_EMIT;
                end
            end
            i2cw_pkg::ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    dp_cmd.clear_timer = 1'b1;
                    state_next         = i2cw_pkg::ST_HOLD;
                end
            end
            i2cw_pkg::ST_HOLD:
            begin
                dp_cmd.count = 1'b1;
                if (status.timer_done)
                begin
                    if (status.final_phase)
                    begin
                        state_next = i2cw_pkg::ST_IDLE;
                    end
                    else
                    begin
                        dp_cmd.advance = 1'b1;
                        state_next     = i2cw_pkg::ST_EMIT;
                    end
                end
            end
            default:
            begin
                state_next = i2cw_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/i2cw_datapath.sv
`timescale 1ns / 1ps

module i2cw_datapath
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [7:0]           cfg_wdata,
    input  logic [2:0]           kind,
    input  logic [7:0]           value,
    input  i2cw_pkg::dp_cmd_t    dp_cmd,
    output i2cw_pkg::dp_status_t status,
    output logic                 scl_level,
    output logic                 sda_level,
    output logic                 last
);

    logic [7:0]                     address_reg;
    logic [7:0]                     shadow_reg;
    logic [7:0]                     shadow_next;
    logic [i2cw_pkg::PHASE_W-1:0]   phase_reg;
    logic [i2cw_pkg::TIMER_W-1:0]   timer_reg;
    logic [i2cw_pkg::PHASE_W-1:0]   offset;
    logic [7:0]                     byte_sel;
    logic                           byte_bit;
    logic                           kind_ok;

    always_comb
    begin
        shadow_next = shadow_reg;
        kind_ok     = 1'b1;
        case (i2cw_pkg::cmd_kind_t'(kind))
            i2cw_pkg::KIND_GAIN:
                shadow_next = (shadow_reg & ~i2cw_pkg::GAIN_MASK) | (value & i2cw_pkg::GAIN_MASK);
            i2cw_pkg::KIND_BIT5:
                shadow_next = (value != 8'd0) ? (shadow_reg | i2cw_pkg::BIT5_MASK)
                                              : (shadow_reg & ~i2cw_pkg::BIT5_MASK);
            i2cw_pkg::KIND_BIT6:
                shadow_next = (value != 8'd0) ? (shadow_reg | i2cw_pkg::BIT6_MASK)
                                              : (shadow_reg & ~i2cw_pkg::BIT6_MASK);
            i2cw_pkg::KIND_SHUTDOWN:
                shadow_next = (value != 8'd0) ? (shadow_reg & ~i2cw_pkg::BIT7_MASK)
                                              : (shadow_reg | i2cw_pkg::BIT7_MASK);
            i2cw_pkg::KIND_DIRECT:
                shadow_next = value;
            default:
                kind_ok = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg <= i2cw_pkg::ADDRESS_RESET;
            shadow_reg  <= i2cw_pkg::SHADOW_RESET;
            phase_reg   <= '0;
            timer_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                address_reg <= cfg_wdata;
            end
            if (dp_cmd.load)
            begin
                shadow_reg <= shadow_next;
                phase_reg  <= '0;
            end
            else if (dp_cmd.advance)
            begin
                phase_reg <= phase_reg + 1'b1;
            end
            if (dp_cmd.clear_timer)
            begin
                timer_reg <= '0;
            end
            else if (dp_cmd.count)
            begin
                timer_reg <= timer_reg + 1'b1;
            end
        end
    end

    assign status = {kind_ok,
                     (timer_reg == i2cw_pkg::TIMER_LAST),
                     (phase_reg == i2cw_pkg::PHASE_LAST)};

    always_comb
    begin
        if (phase_reg <= i2cw_pkg::PHASE_ADDR_HI)
        begin
            offset   = phase_reg - i2cw_pkg::PHASE_ADDR_LO;
            byte_sel = address_reg;
        end
        else
        begin
            offset   = phase_reg - i2cw_pkg::PHASE_DATA_LO;
            byte_sel = shadow_reg;
        end
        byte_bit = (offset[4]) ? 1'b1 : byte_sel[~offset[3:1]];
    end

    always_comb
    begin
        scl_level = 1'b1;
        sda_level = 1'b1;
        last      = 1'b0;
        case (phase_reg) inside
            i2cw_pkg::PHASE_START:
            begin
                scl_level = 1'b1;
                sda_level = 1'b0;
            end
            [i2cw_pkg::PHASE_ADDR_LO:i2cw_pkg::PHASE_DATA_HI]:
            begin
                scl_level = offset[0];
                sda_level = byte_bit;
            end
            i2cw_pkg::PHASE_STOP_0:
            begin
                scl_level = 1'b0;
                sda_level = 1'b1;
            end
            i2cw_pkg::PHASE_STOP_1:
            begin
                scl_level = 1'b0;
                sda_level = 1'b0;
            end
            i2cw_pkg::PHASE_STOP_2:
            begin
                scl_level = 1'b1;
                sda_level = 1'b0;
            end
            i2cw_pkg::PHASE_LAST:
            begin
                scl_level = 1'b1;
                sda_level = 1'b1;
                last      = 1'b1;
            end
            default:
            begin
                scl_level = 1'b1;
                sda_level = 1'b1;
            end
        endcase
    end

endmodule

>>> hdl/i2c_two_byte_write_master.sv
`timescale 1ns / 1ps

// Command-driven I2C write master producing a stream of pin phases.
// The cmd channel takes one command (kind, value) that updates the shadow
// byte; kinds above the direct-byte code are taken and discarded without output.
// Each accepted command produces 41 transfers on the phase channel: start,
// the address byte, the shadow byte, each with an ack slot, and a stop.
// Each transfer carries one SCL/SDA level pair; last marks the final stop phase.
// After a phase is transferred the block holds it until the half-bit timer
// in the datapath expires before offering the next. One command is handled
// at a time; cmd.ready is high only while no transaction runs.
// If the receiver stalls, the current phase is held and the timer waits.
// The address register is written through cfg_we/cfg_wdata; the user must
// write it only while idle; the block itself does not enforce this.
// Reset returns to idle, the address to 0x9A and the shadow byte to 0xFF.
module i2c_two_byte_write_master
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [7:0]   cfg_wdata,
    i2cw_cmd_if.sink     cmd,
    i2cw_phase_if.source phase
);

    i2cw_pkg::dp_cmd_t    dp_cmd;
    i2cw_pkg::dp_status_t status;

    i2cw_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .out_valid (phase.valid),
        .out_ready (phase.ready),
        .status    (status),
        .dp_cmd    (dp_cmd)
    );

    i2cw_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .kind      (cmd.kind),
        .value     (cmd.value),
        .dp_cmd    (dp_cmd),
        .status    (status),
        .scl_level (phase.scl_level),
        .sda_level (phase.sda_level),
        .last      (phase.last)
    );

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int CLK_HALF_NS    = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 2 * i2cw_pkg::HALF_BIT_CYCLES + 16;
    localparam int WATCHDOG_LIMIT = 10 * (2 * i2cw_pkg::HALF_BIT_CYCLES + 64);
    localparam int RANDOM_PER_SEG = 26;
    localparam int DRAIN_EVERY    = 10;
    localparam int MAX_REPORTS    = 10;
    localparam int DIRECTED_ROWS  = 20;

    localparam logic [2:0] KIND_UNUSED_LO  = 3'd5;
    localparam logic [2:0] KIND_UNUSED_MID = 3'd6;
    localparam logic [2:0] KIND_UNUSED_HI  = 3'd7;

    typedef struct packed {
        logic scl;
        logic sda;
        logic last;
    } pin_phase_t;

    typedef struct {
        logic [2:0] kind;
        logic [7:0] value;
        bit         write_addr;
        logic [7:0] addr_value;
        bit         typed;
        logic [7:0] typed_shadow;
    } cmd_row_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;

    i2cw_cmd_if   cmd_bus ();
    i2cw_phase_if phase_bus ();

    i2c_two_byte_write_master DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_bus.sink),
        .phase     (phase_bus.source)
    );

    pin_phase_t pin_phase_q [$];
    logic [7:0] addr_model;
    logic [7:0] shadow_model;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         error_count;
    int         report_count;
    int         phase_count;
    int         cmd_count;
    int         ignored_count;
    int         addr_writes;

    cmd_row_t directed_rows [DIRECTED_ROWS] = '{
        '{i2cw_pkg::KIND_GAIN,     8'h00, 1'b0, 8'h00, 1'b1, 8'hE0},
        '{i2cw_pkg::KIND_GAIN,     8'hFF, 1'b0, 8'h00, 1'b1, 8'hFF},
        '{i2cw_pkg::KIND_BIT5,     8'h00, 1'b0, 8'h00, 1'b1, 8'hDF},
        '{i2cw_pkg::KIND_BIT5,     8'h01, 1'b0, 8'h00, 1'b1, 8'hFF},
        '{i2cw_pkg::KIND_BIT6,     8'h00, 1'b0, 8'h00, 1'b1, 8'hBF},
        '{i2cw_pkg::KIND_BIT6,     8'h80, 1'b0, 8'h00, 1'b1, 8'hFF},
        '{i2cw_pkg::KIND_SHUTDOWN, 8'h01, 1'b0, 8'h00, 1'b1, 8'h7F},
        '{i2cw_pkg::KIND_SHUTDOWN, 8'h00, 1'b0, 8'h00, 1'b1, 8'hFF},
        '{i2cw_pkg::KIND_DIRECT,   8'h00, 1'b1, 8'h00, 1'b1, 8'h00},
        '{KIND_UNUSED_LO,          8'hFF, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_DIRECT,   8'hFF, 1'b1, 8'hFF, 1'b1, 8'hFF},
        '{KIND_UNUSED_MID,         8'h00, 1'b0, 8'h00, 1'b0, 8'h00},
        '{KIND_UNUSED_HI,          8'hAA, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_DIRECT,   8'hA5, 1'b0, 8'h00, 1'b1, 8'hA5},
        '{i2cw_pkg::KIND_GAIN,     8'h55, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_SHUTDOWN, 8'h80, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_BIT5,     8'hFE, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_BIT6,     8'h7F, 1'b0, 8'h00, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_GAIN,     8'h1F, 1'b1, 8'h55, 1'b0, 8'h00},
        '{i2cw_pkg::KIND_DIRECT,   8'h5A, 1'b0, 8'h00, 1'b0, 8'h00}
    };

    initial clk = 1'b0;
    always #CLK_HALF_NS clk = ~clk;

    function automatic logic [7:0] next_shadow(input logic [7:0] cur, input logic [2:0] kind,
                                               input logic [7:0] value, output bit taken);
        logic [7:0] res;
        res   = cur;
        taken = 1'b1;
        case (kind)
            i2cw_pkg::KIND_GAIN:
                res = (cur & ~i2cw_pkg::GAIN_MASK) | (value & i2cw_pkg::GAIN_MASK);
            i2cw_pkg::KIND_BIT5:
                res = (value != 8'h00) ? (cur | i2cw_pkg::BIT5_MASK)
                                       : (cur & ~i2cw_pkg::BIT5_MASK);
            i2cw_pkg::KIND_BIT6:
                res = (value != 8'h00) ? (cur | i2cw_pkg::BIT6_MASK)
                                       : (cur & ~i2cw_pkg::BIT6_MASK);
            i2cw_pkg::KIND_SHUTDOWN:
                res = (value != 8'h00) ? (cur & ~i2cw_pkg::BIT7_MASK)
                                       : (cur | i2cw_pkg::BIT7_MASK);
            i2cw_pkg::KIND_DIRECT:
                res = value;
            default:
                taken = 1'b0;
        endcase
        return res;
    endfunction

    task automatic push_phase(input logic scl, input logic sda, input logic last);
        pin_phase_t p;
        p.scl  = scl;
        p.sda  = sda;
        p.last = last;
        pin_phase_q.push_back(p);
    endtask

    task automatic push_byte(input logic [7:0] b);
        for (int i = 7; i >= 0; i--)
        begin
            push_phase(1'b0, b[i], 1'b0);
            push_phase(1'b1, b[i], 1'b0);
        end
        push_phase(1'b0, 1'b1, 1'b0);
        push_phase(1'b1, 1'b1, 1'b0);
    endtask

    task automatic predict_write(input logic [7:0] data_byte);
        push_phase(1'b1, 1'b0, 1'b0);
        push_byte(addr_model);
        push_byte(data_byte);
        push_phase(1'b0, 1'b1, 1'b0);
        push_phase(1'b0, 1'b0, 1'b0);
        push_phase(1'b1, 1'b0, 1'b0);
        push_phase(1'b1, 1'b1, 1'b1);
    endtask

    task automatic drain_phases();
        while (pin_phase_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_cmd(input logic [2:0] kind, input logic [7:0] value,
                            input bit typed, input logic [7:0] typed_shadow);
        logic [7:0] nxt;
        bit         taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_bus.valid = 1'b0;
            @(negedge clk);
        end
        cmd_bus.valid = 1'b1;
        cmd_bus.kind  = kind;
        cmd_bus.value = value;
        do
        begin
            @(posedge clk);
        end while (!cmd_bus.ready);
        nxt = next_shadow(shadow_model, kind, value, taken);
        if (taken)
        begin
            shadow_model = nxt;
            predict_write(typed ? typed_shadow : nxt);
            cmd_count++;
        end
        else
        begin
            ignored_count++;
        end
        @(negedge clk);
        cmd_bus.valid = 1'b0;
    endtask

    // The block holds the final phase for a half-bit period before it is idle again.
    task automatic write_address(input logic [7:0] v);
        drain_phases();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge clk);
        cfg_we     = 1'b0;
        addr_model = v;
        addr_writes++;
    endtask

    always @(negedge clk)
    begin
        phase_bus.ready = ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        pin_phase_t got;
        pin_phase_t want;
        if (rst_n && phase_bus.valid && phase_bus.ready)
        begin
            got.scl  = phase_bus.scl_level;
            got.sda  = phase_bus.sda_level;
            got.last = phase_bus.last;
            phase_count++;
            if (pin_phase_q.size() == 0)
            begin
                error_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("Unexpected phase transfer: scl %b sda %b last %b",
                             got.scl, got.sda, got.last);
                end
            end
            else
            begin
                want = pin_phase_q.pop_front();
                if (got.scl !== want.scl || got.sda !== want.sda || got.last !== want.last)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        $display("Phase mismatch: expected scl %b sda %b last %b, got %b %b %b",
                                 want.scl, want.sda, want.last, got.scl, got.sda, got.last);
                    end
                end
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (cmd_bus.valid && cmd_bus.ready)
                || (phase_bus.valid && phase_bus.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog expired with %0d phases outstanding", pin_phase_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0] kind;
        logic [7:0] value;
        int         counted;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = 8'h00;
        cmd_bus.valid   = 1'b0;
        cmd_bus.kind    = 3'd0;
        cmd_bus.value   = 8'h00;
        phase_bus.ready = 1'b0;
        addr_model      = i2cw_pkg::ADDRESS_RESET;
        shadow_model    = i2cw_pkg::SHADOW_RESET;
        error_count     = 0;
        report_count    = 0;
        phase_count     = 0;
        cmd_count       = 0;
        ignored_count   = 0;
        addr_writes     = 0;
        send_idle_pct   = 6;
        recv_idle_pct   = 55;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].write_addr)
                write_address(directed_rows[r].addr_value);
            send_cmd(directed_rows[r].kind, directed_rows[r].value,
                     directed_rows[r].typed, directed_rows[r].typed_shadow);
        end

        for (int seg = 0; seg < 3; seg++)
        begin
            case (seg)
                0:
                begin
                    send_idle_pct = 6;
                    recv_idle_pct = 55;
                    write_address(8'($urandom));
                end
                1:
                begin
                    send_idle_pct = 55;
                    recv_idle_pct = 6;
                    write_address(8'hFF);
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    write_address(8'($urandom));
                end
            endcase
            counted = 0;
            while (counted < RANDOM_PER_SEG)
            begin
                if ($urandom_range(9) == 0)
                    kind = 3'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
                else
                    kind = 3'($urandom_range(i2cw_pkg::KIND_GAIN, i2cw_pkg::KIND_DIRECT));
                case ($urandom_range(7))
                    0:       value = 8'h00;
                    1:       value = 8'hFF;
                    default: value = 8'($urandom);
                endcase
                send_cmd(kind, value, 1'b0, 8'h00);
                if (kind <= i2cw_pkg::KIND_DIRECT)
                begin
                    counted++;
                    if (counted % DRAIN_EVERY == 0)
                        drain_phases();
                end
            end
        end

        drain_phases();
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (pin_phase_q.size() != 0)
            error_count++;

        $display("Covered %0d write transactions and %0d ignored commands, %0d phases checked,",
                 cmd_count, ignored_count, phase_count);
        $display("over %0d address settings and three handshake idling patterns.", addr_writes);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
